// ===== rtl/core/rpq_pkg.sv =====
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared beat types and codes for the priority ready-queue scheduler.
// ----------------------------------------------------------------------------
package rpq_pkg;

    // request kinds
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_WAKEUP = 3'd1;
    localparam logic [2:0] KIND_BLOCK  = 3'd2;
    localparam logic [2:0] KIND_EXIT   = 3'd3;
    localparam logic [2:0] KIND_SCHED  = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NOFREE  = 2'd2;

    // per-slot task state, stored in the task table
    typedef enum logic [2:0] {
        TS_FREE    = 3'd0,
        TS_READY   = 3'd1,
        TS_RUNNING = 3'd2,
        TS_BLOCKED = 3'd3,
        TS_IDLE    = 3'd4
    } t_task_st;

    typedef struct packed {
        logic [2:0] kind;
        logic [4:0] priority_req;
        logic [3:0] task_id;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] created_task;
        logic       switched;
        logic [3:0] running_now;
        logic [3:0] running_before;
        logic [4:0] ready_count;
    } t_out_beat;

endpackage

// ===== rtl/core/priority_ready_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top
// Bitmap priority ready-queue task scheduler with valid/ready beat channels.
// ----------------------------------------------------------------------------
// One request beat is taken per cycle while results are taken. The request
// is captured in an input register; once the result register can accept it,
// the task table update and the result are computed in one pass (priority
// encoders over the level bitmap, the queue-head match over the task slots
// and the lowest free slot) and loaded into the result register. A full
// result register that is not taken stalls the input side. There is no
// clearing pass after reset.
module priority_ready_queue_scheduler_top
    import rpq_pkg::*;
#(
    parameter int TASK_SLOTS      = 16,
    parameter int PRIORITY_LEVELS = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;
    logic      advance;
    t_out_beat core_res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_beat;
        end
    end

    rpq_core #(
        .TASK_SLOTS      (TASK_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (advance),
        .i_item   (r_in),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed beat did not reach the result register");

    a_switch_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.switched == (r_out.running_now != r_out.running_before)))
        else $error("switched flag disagrees with running task fields");

    a_created_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.created_task != 4'd0)) |-> (r_out.status == STAT_OK))
        else $error("created slot reported on a failed request");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (int'(r_out.ready_count) <= TASK_SLOTS - 1))
        else $error("ready count exceeds available task slots");

endmodule

// ===== rtl/core/rpq_prienc.sv =====
// ----------------------------------------------------------------------------
// rpq_prienc
// Priority encoder: index of the highest or the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module rpq_prienc #(
    parameter int WIDTH     = 16,
    parameter bit LOW_FIRST = 1'b0,
    localparam int IW       = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic [WIDTH-1:0] i_vec,
    output logic             o_found,
    output logic [IW-1:0]    o_index
);

    always_comb begin
        o_found = |i_vec;
        o_index = '0;
        if (LOW_FIRST) begin
            for (int i = WIDTH - 1; i >= 0; i--) begin
                if (i_vec[i]) begin
                    o_index = IW'(i);
                end
            end
        end else begin
            for (int i = 0; i < WIDTH; i++) begin
                if (i_vec[i]) begin
                    o_index = IW'(i);
                end
            end
        end
    end

endmodule

// ===== rtl/core/rpq_core.sv =====
// ----------------------------------------------------------------------------
// rpq_core
// Task table, FIFO order matrix and the single-pass request logic.
// ----------------------------------------------------------------------------
module rpq_core
    import rpq_pkg::*;
#(
    parameter int TASK_SLOTS      = 16,
    parameter int PRIORITY_LEVELS = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  t_in_beat  i_item,
    output t_out_beat o_result
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(PRIORITY_LEVELS + 1);
    localparam int QW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

    t_task_st                r_state [TASK_SLOTS];
    logic [LW-1:0]           r_level [TASK_SLOTS];
    // r_older[i][j]: slot j was queued before slot i (valid only while both ready)
    logic [TASK_SLOTS-1:0]   r_older [TASK_SLOTS];
    logic [SW-1:0]           r_cur;
    logic [SW-1:0]           r_live;

    t_task_st                n_state [TASK_SLOTS];
    logic [LW-1:0]           n_level [TASK_SLOTS];
    logic [SW-1:0]           n_cur;
    logic [SW-1:0]           n_live;

    logic [TASK_SLOTS-1:0]   queued;
    logic [TASK_SLOTS-1:0]   free_vec;
    logic [TASK_SLOTS-1:0]   eligible;
    logic [TASK_SLOTS-1:0]   head;
    logic [PRIORITY_LEVELS-1:0] nonempty;

    logic                    best_found;
    logic [QW-1:0]           best_idx;
    logic [LW-1:0]           best_lvl;
    logic                    pick_found;
    logic [SW-1:0]           pick_slot;
    logic                    free_found;
    logic [SW-1:0]           free_slot;

    logic                    lvl_ok;
    logic [LW-1:0]           new_lvl;
    logic [SW+3:0]           id_ext;
    logic [SW-1:0]           id_slot;
    logic                    id_ok;
    t_task_st                cur_st;
    t_task_st                sched_st;
    logic                    do_sched;
    logic                    push_en;
    logic [SW-1:0]           push_slot;
    logic [1:0]              status;
    logic [SW-1:0]           created;
    logic [SW+3:0]           created_ext;
    logic [SW+3:0]           now_ext;
    logic [SW+3:0]           before_ext;
    logic [SW+4:0]           live_ext;

    // ready tasks are exactly the queued ones
    always_comb begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            queued[i]   = (r_state[i] == TS_READY);
            free_vec[i] = (r_state[i] == TS_FREE);
        end
    end

    always_comb begin
        nonempty = '0;
        for (int q = 0; q < PRIORITY_LEVELS; q++) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (queued[i] && (r_level[i] == LW'(q + 1))) begin
                    nonempty[q] = 1'b1;
                end
            end
        end
    end

    rpq_prienc #(.WIDTH(PRIORITY_LEVELS), .LOW_FIRST(1'b0)) u_best (
        .i_vec   (nonempty),
        .o_found (best_found),
        .o_index (best_idx)
    );

    assign best_lvl = LW'(best_idx) + LW'(1);

    // queue head: oldest ready task at the best level
    always_comb begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            eligible[i] = queued[i] && (r_level[i] == best_lvl);
        end
        for (int i = 0; i < TASK_SLOTS; i++) begin
            head[i] = eligible[i] && !(|(eligible & r_older[i]));
        end
    end

    rpq_prienc #(.WIDTH(TASK_SLOTS), .LOW_FIRST(1'b0)) u_pick (
        .i_vec   (head),
        .o_found (pick_found),
        .o_index (pick_slot)
    );

    rpq_prienc #(.WIDTH(TASK_SLOTS), .LOW_FIRST(1'b1)) u_free (
        .i_vec   (free_vec),
        .o_found (free_found),
        .o_index (free_slot)
    );

    assign lvl_ok  = (i_item.priority_req != 5'd0) &&
                     (int'(i_item.priority_req) <= PRIORITY_LEVELS);
    assign new_lvl = LW'(i_item.priority_req);
    assign id_ext  = {{SW{1'b0}}, i_item.task_id};
    assign id_slot = id_ext[SW-1:0];
    assign id_ok   = int'(i_item.task_id) < TASK_SLOTS;
    assign cur_st  = r_state[r_cur];

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_cur     = r_cur;
        n_live    = r_live;
        push_en   = 1'b0;
        push_slot = r_cur;
        status    = STAT_INVALID;
        created   = '0;
        do_sched  = 1'b0;
        sched_st  = cur_st;

        case (i_item.kind)
            KIND_CREATE: begin
                if (lvl_ok) begin
                    status = STAT_NOFREE;
                    if (free_found) begin
                        n_state[free_slot] = TS_READY;
                        n_level[free_slot] = new_lvl;
                        push_en            = 1'b1;
                        push_slot          = free_slot;
                        n_live             = r_live + SW'(1);
                        created            = free_slot;
                        status             = STAT_OK;
                    end
                end
            end
            KIND_WAKEUP: begin
                if (id_ok && (r_state[id_slot] == TS_BLOCKED)) begin
                    n_state[id_slot] = TS_READY;
                    push_en          = 1'b1;
                    push_slot        = id_slot;
                    n_live           = r_live + SW'(1);
                    status           = STAT_OK;
                end
            end
            KIND_BLOCK: begin
                if (cur_st == TS_RUNNING) begin
                    n_state[r_cur] = TS_BLOCKED;
                    if (r_live != '0) begin
                        n_live = r_live - SW'(1);
                    end
                    status = STAT_OK;
                end
            end
            KIND_EXIT: begin
                if (cur_st == TS_RUNNING) begin
                    n_state[r_cur] = TS_FREE;
                    if (r_live != '0) begin
                        n_live = r_live - SW'(1);
                    end
                    do_sched = 1'b1;
                    sched_st = TS_FREE;
                    status   = STAT_OK;
                end
            end
            KIND_SCHED: begin
                do_sched = 1'b1;
                status   = STAT_OK;
            end
            default: begin
            end
        endcase

        if (do_sched) begin
            if (!best_found) begin
                if (!((sched_st == TS_RUNNING) || (sched_st == TS_IDLE))) begin
                    n_cur = '0;
                end
            end else if (!((sched_st == TS_RUNNING) && (r_level[r_cur] > best_lvl))
                         && pick_found) begin
                n_state[pick_slot] = TS_RUNNING;
                n_cur              = pick_slot;
                // preempted task goes behind everything still queued
                if (sched_st == TS_RUNNING) begin
                    n_state[r_cur] = TS_READY;
                    push_en        = 1'b1;
                    push_slot      = r_cur;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_state[i] <= (i == 0) ? TS_IDLE : TS_FREE;
                r_level[i] <= '0;
            end
            r_cur  <= '0;
            r_live <= '0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_level <= n_level;
            r_cur   <= n_cur;
            r_live  <= n_live;
        end
    end

    // order matrix: a pushed slot is younger than every queued slot
    always_ff @(posedge i_clk) begin
        if (i_adv && push_en) begin
            for (int j = 0; j < TASK_SLOTS; j++) begin
                if (SW'(j) == push_slot) begin
                    r_older[j] <= queued;
                end else begin
                    r_older[j][push_slot] <= 1'b0;
                end
            end
        end
    end

    assign created_ext = {4'b0, created};
    assign now_ext     = {4'b0, n_cur};
    assign before_ext  = {4'b0, r_cur};
    assign live_ext    = {5'b0, n_live};

    always_comb begin
        o_result.status         = status;
        o_result.created_task   = created_ext[3:0];
        o_result.switched       = (n_cur != r_cur);
        o_result.running_now    = now_ext[3:0];
        o_result.running_before = before_ext[3:0];
        o_result.ready_count    = live_ext[4:0];
    end

endmodule

// ===== dv/sched_result_checker.sv =====
// ----------------------------------------------------------------------------
// sched_result_checker
// Watches both beat channels of the scheduler. It keeps its own copy of the
// task table, the per-level ready queues and the ready bitmap. From those it
// works out the expected result of every accepted request and compares each
// result beat, field by field, against the oldest one still waiting.
// ----------------------------------------------------------------------------
module sched_result_checker
    import rpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_beat,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_switches,
    output int        o_invalid,
    output int        o_full
);

    localparam int N_SLOTS  = 16;
    localparam int N_LEVELS = 31;

    t_task_st           slot_st  [N_SLOTS];
    logic [4:0]         slot_lvl [N_SLOTS];
    logic [3:0]         q_next   [N_SLOTS];
    logic [3:0]         q_first  [N_LEVELS];
    logic [3:0]         q_last   [N_LEVELS];
    logic [N_LEVELS-1:0] ready_map;
    logic [3:0]         cur_task;
    logic [4:0]         live_tasks;

    t_out_beat exp_results[$];

    function automatic void reset_model();
        for (int s = 0; s < N_SLOTS; s++) begin
            slot_st[s]  = TS_FREE;
            slot_lvl[s] = '0;
            q_next[s]   = '0;
        end
        for (int l = 0; l < N_LEVELS; l++) begin
            q_first[l] = '0;
            q_last[l]  = '0;
        end
        slot_st[0] = TS_IDLE;
        ready_map  = '0;
        cur_task   = '0;
        live_tasks = '0;
    endfunction

    // append a slot at the tail of its level's queue
    function automatic void enqueue(input logic [3:0] slot);
        int q;
        q = int'(slot_lvl[slot]) - 1;
        if (ready_map[q]) begin
            q_next[q_last[q]] = slot;
            q_last[q] = slot;
        end else begin
            q_first[q] = slot;
            q_last[q]  = slot;
            ready_map[q] = 1'b1;
        end
    endfunction

    function automatic void pick_next();
        logic [3:0] was;
        t_task_st   was_st;
        logic [3:0] chosen;
        int         best;
        was    = cur_task;
        was_st = slot_st[was];
        best   = 0;
        for (int l = N_LEVELS; l >= 1; l--) begin
            if (best == 0 && ready_map[l-1]) best = l;
        end
        if (best == 0) begin
            // nothing waiting: a blocked or freed current task hands over to idle
            if (was_st != TS_RUNNING && was_st != TS_IDLE) cur_task = '0;
            return;
        end
        // running task keeps the cpu only when strictly above the best waiter
        if (was_st == TS_RUNNING && int'(slot_lvl[was]) > best) return;
        chosen = q_first[best-1];
        if (chosen == q_last[best-1]) ready_map[best-1] = 1'b0;
        else q_first[best-1] = q_next[chosen];
        slot_st[chosen] = TS_RUNNING;
        cur_task = chosen;
        // preempted task goes behind its peers, after the pick
        if (was_st == TS_RUNNING) begin
            slot_st[was] = TS_READY;
            enqueue(was);
        end
    endfunction

    function automatic t_out_beat apply_request(input t_in_beat rq);
        t_out_beat  res;
        logic [3:0] prev;
        logic       found;
        prev  = cur_task;
        found = 1'b0;
        res   = '0;
        res.status = STAT_INVALID;
        case (rq.kind)
            KIND_CREATE: begin
                if (rq.priority_req >= 1 && rq.priority_req <= N_LEVELS) begin
                    res.status = STAT_NOFREE;
                    for (int s = 0; s < N_SLOTS; s++) begin
                        if (!found && slot_st[s] == TS_FREE) begin
                            found = 1'b1;
                            slot_st[s]  = TS_READY;
                            slot_lvl[s] = rq.priority_req;
                            enqueue(4'(s));
                            live_tasks++;
                            res.created_task = 4'(s);
                            res.status = STAT_OK;
                        end
                    end
                end
            end
            KIND_WAKEUP: begin
                if (slot_st[rq.task_id] == TS_BLOCKED) begin
                    slot_st[rq.task_id] = TS_READY;
                    enqueue(rq.task_id);
                    live_tasks++;
                    res.status = STAT_OK;
                end
            end
            KIND_BLOCK: begin
                if (slot_st[cur_task] == TS_RUNNING) begin
                    slot_st[cur_task] = TS_BLOCKED;
                    if (live_tasks != 0) live_tasks--;
                    res.status = STAT_OK;
                end
            end
            KIND_EXIT: begin
                if (slot_st[cur_task] == TS_RUNNING) begin
                    slot_st[cur_task] = TS_FREE;
                    if (live_tasks != 0) live_tasks--;
                    pick_next();
                    res.status = STAT_OK;
                end
            end
            KIND_SCHED: begin
                pick_next();
                res.status = STAT_OK;
            end
            default: ;
        endcase
        res.switched       = (cur_task != prev);
        res.running_now    = cur_task;
        res.running_before = prev;
        res.ready_count    = live_tasks;
        return res;
    endfunction

    function automatic int field_ok(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            return 0;
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        int        ok;
        if (!i_rst_n) begin
            reset_model();
            exp_results.delete();
            o_errors   = 0;
            o_results  = 0;
            o_switches = 0;
            o_invalid  = 0;
            o_full     = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (exp_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    o_errors++;
                end else begin
                    want = exp_results.pop_front();
                    ok = 1;
                    ok &= field_ok("status", want.status, i_out_beat.status);
                    ok &= field_ok("created_task", want.created_task,
                                   i_out_beat.created_task);
                    ok &= field_ok("switched", want.switched, i_out_beat.switched);
                    ok &= field_ok("running_now", want.running_now,
                                   i_out_beat.running_now);
                    ok &= field_ok("running_before", want.running_before,
                                   i_out_beat.running_before);
                    ok &= field_ok("ready_count", want.ready_count,
                                   i_out_beat.ready_count);
                    if (!ok) o_errors++;
                    o_results++;
                    if (want.switched) o_switches++;
                    if (want.status == STAT_INVALID) o_invalid++;
                    if (want.status == STAT_NOFREE) o_full++;
                end
            end
            if (i_in_valid && i_in_ready) exp_results.push_back(apply_request(i_in_beat));
        end
        o_pending = exp_results.size();
    end

endmodule

// ===== dv/tb_priority_ready_queue_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// tb_priority_ready_queue_scheduler_top
// Drives scheduler requests with random gaps and result back-pressure,
// including one long receiver hold-off. A directed opening covers the corner
// cases, then a weighted random mix of task lifecycle requests follows. The
// checker beside the block does the predicting; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_priority_ready_queue_scheduler_top;
    import rpq_pkg::*;

    localparam logic [2:0] KIND_RSVD_LO = 3'd5;
    localparam logic [2:0] KIND_RSVD_HI = 3'd7;
    localparam int         N_RANDOM     = 600;
    localparam int         HOLD_AT      = 380;
    localparam int         HOLD_CYCLES  = 300;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_ready;
    t_out_beat out_beat;

    int errors, pending, results, switches, invalid_cnt, full_cnt;
    int reqs_sent;

    priority_ready_queue_scheduler_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    sched_result_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_beat  (out_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_switches  (switches),
        .o_invalid   (invalid_cnt),
        .o_full      (full_cnt)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #3_000_000;
        $display("tb_priority_ready_queue_scheduler_top: errors");
        $finish;
    end

    // mostly back-to-back or short, now and then a long gap
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_in_beat req(input logic [2:0] kind, input logic [4:0] lvl,
                                     input logic [3:0] id);
        t_in_beat b;
        b.kind         = kind;
        b.priority_req = lvl;
        b.task_id      = id;
        return b;
    endfunction

    function automatic t_in_beat rand_req();
        t_in_beat b;
        int       r;
        b = req(KIND_SCHED, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
        r = $urandom_range(0, 99);
        if (r < 22) begin
            b.kind = KIND_CREATE;
            r = $urandom_range(0, 99);
            // a few levels in heavy use so queues get deep and round robin shows
            if (r < 70) b.priority_req = 5'($urandom_range(1, 4));
            else if (r < 95) b.priority_req = 5'($urandom_range(0, 31));
            else b.priority_req = '0;
        end
        else if (r < 44) b.kind = KIND_WAKEUP;
        else if (r < 58) b.kind = KIND_BLOCK;
        else if (r < 72) b.kind = KIND_EXIT;
        else if (r < 96) b.kind = KIND_SCHED;
        else b.kind = 3'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
        return b;
    endfunction

    task automatic send_req(input t_in_beat b);
        int gap;
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        reqs_sent++;
        // no sender gaps around the hold-off so the block backs up
        gap = (reqs_sent >= HOLD_AT && reqs_sent < HOLD_AT + 80) ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side
    initial begin
        logic held;
        int   stall;
        held = 1'b0;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && reqs_sent >= HOLD_AT) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (reqs_sent >= 520 && reqs_sent < 580) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end else begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        reqs_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_req(req(KIND_SCHED, 5'd0, 4'd0));     // empty queues, idle stays
        send_req(req(KIND_BLOCK, 5'd0, 4'd0));     // idle cannot block
        send_req(req(KIND_EXIT, 5'd31, 4'd15));    // idle cannot exit
        send_req(req(KIND_CREATE, 5'd0, 4'd0));    // level zero rejected
        send_req(req(KIND_CREATE, 5'd31, 4'd0));   // slot 1
        send_req(req(KIND_CREATE, 5'd1, 4'd0));    // slot 2
        send_req(req(KIND_CREATE, 5'd1, 4'd0));    // slot 3
        send_req(req(KIND_SCHED, 5'd0, 4'd0));     // top level wins
        send_req(req(KIND_SCHED, 5'd0, 4'd0));     // strictly higher keeps cpu
        send_req(req(KIND_EXIT, 5'd0, 4'd0));
        send_req(req(KIND_SCHED, 5'd0, 4'd0));     // round robin at level 1
        send_req(req(KIND_BLOCK, 5'd0, 4'd0));
        send_req(req(KIND_BLOCK, 5'd0, 4'd0));     // current already blocked
        send_req(req(KIND_WAKEUP, 5'd0, 4'd3));    // wake the blocked current task
        send_req(req(KIND_SCHED, 5'd0, 4'd0));
        send_req(req(KIND_WAKEUP, 5'd0, 4'd9));    // free slot, rejected
        send_req(req(KIND_RSVD_HI, 5'd0, 4'd0));
        // fill every free slot, then one more to hit the full table
        for (int i = 0; i < 14; i++) begin
            send_req(req(KIND_CREATE, 5'($urandom_range(1, 31)), 4'd0));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            send_req(rand_req());
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests sent, %0d result beats checked", reqs_sent, results);
        $display("%0d task switches, %0d invalid requests, %0d full-table rejects",
                 switches, invalid_cnt, full_cnt);
        if (errors == 0) begin
            $display("tb_priority_ready_queue_scheduler_top: clean");
        end else begin
            $display("tb_priority_ready_queue_scheduler_top: errors");
        end
        $finish;
    end

endmodule
